// File: hdl/assert_macros.svh
// Assertion helpers for the predictor sequencer (slsf_ctrl).
// Both sample on the rising clock edge and are off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/slsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsf_pkg
// Shared constants and types of the sign-LMS synthesis predictor.
// ----------------------------------------------------------------------------
package slsf_pkg;

  // Built tap count and fixed-point scaling
  localparam int MAX_TAPS  = 32;
  localparam int FRAC_BITS = 14;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 6;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 5;
  localparam int SHIFT_W = 5;

  // Derived widths: tap address and a counter that can hold MAX_TAPS itself
  localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);

  localparam logic [CFG_W-1:0]  TAPS_RESET = CFG_W'(8);
  localparam logic [DATA_W-1:0] ROUND_HALF = DATA_W'(1) << (FRAC_BITS - 1);

  // Item modes
  localparam logic [MODE_W-1:0] MODE_RESIDUAL    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_LOAD_WEIGHT = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LOAD_HIST   = MODE_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PUSH
  } state_t;

  // One write port of a store
  typedef struct packed {
    logic              we;
    logic [TAP_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic start;   // residual item accepted: seed accumulator
    logic s1_vld;  // read data of one tap present this cycle
    logic w_ok;    // weight entry has been written since reset
    logic h_ok;    // history entry has been written since reset
    logic neg;     // residual is negative
  } dp_ctrl_t;

endpackage

// File: hdl/sign_lms_synthesis_filter_core.sv
`timescale 1ns / 1ps
// Load items are written in the accepting cycle; a residual item gives its sample
//   after the tap walk, the drain and the push into the result register.
// A new residual item is taken only after the last is pushed, as the single read
//   port of each store walks one tap per cycle; loads are taken every cycle in idle.
// Reset: both stores read as zero, ring position zero, tap count 8, no item held.
// ----------------------------------------------------------------------------
// sign_lms_synthesis_filter_core
// Decoder-side sign-LMS adaptive predictor with weights and history in RAM.
// ----------------------------------------------------------------------------
module sign_lms_synthesis_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration
  input  logic                                cfg_wr_en,
  input  logic [slsf_pkg::CFG_W-1:0]          cfg_wr_data,
  // Input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [slsf_pkg::MODE_W-1:0]         in_mode,
  input  logic [slsf_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [slsf_pkg::DATA_W-1:0]  in_value,
  input  logic [slsf_pkg::SHIFT_W-1:0]        in_load_shift,
  // Result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [slsf_pkg::DATA_W-1:0]  out_sample_out
);

  slsf_pkg::ram_wr_t           w_wr;
  slsf_pkg::ram_wr_t           h_wr;
  slsf_pkg::dp_ctrl_t          dp_ctl;
  logic [slsf_pkg::TAP_AW-1:0] w_raddr;
  logic [slsf_pkg::TAP_AW-1:0] h_raddr;
  logic [slsf_pkg::DATA_W-1:0] w_rd;
  logic [slsf_pkg::DATA_W-1:0] h_rd;
  logic [slsf_pkg::DATA_W-1:0] w_upd;
  logic [slsf_pkg::DATA_W-1:0] synth;
  logic                        dp_busy;
  logic                        out_free;
  logic                        push;
  logic                        out_valid_r;
  logic [slsf_pkg::DATA_W-1:0] out_data_r;

  slsf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .in_load_shift  (in_load_shift),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .w_wr           (w_wr),
    .h_wr           (h_wr),
    .w_raddr        (w_raddr),
    .h_raddr        (h_raddr),
    .dp_ctl         (dp_ctl),
    .w_upd          (w_upd),
    .dp_busy        (dp_busy),
    .synth          (synth),
    .out_free       (out_free),
    .push           (push)
  );

  slsf_ram #(
    .WIDTH (slsf_pkg::DATA_W),
    .DEPTH (slsf_pkg::MAX_TAPS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_wr.we),
    .waddr (w_wr.addr),
    .wdata (w_wr.data),
    .raddr (w_raddr),
    .rdata (w_rd)
  );

  slsf_ram #(
    .WIDTH (slsf_pkg::DATA_W),
    .DEPTH (slsf_pkg::MAX_TAPS)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_wr.we),
    .waddr (h_wr.addr),
    .wdata (h_wr.data),
    .raddr (h_raddr),
    .rdata (h_rd)
  );

  slsf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dp_ctl),
    .residual (in_value),
    .w_rd     (w_rd),
    .h_rd     (h_rd),
    .w_upd    (w_upd),
    .busy     (dp_busy),
    .synth    (synth)
  );

  // Result register: take a new sample once the held one is gone
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= synth;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule

// File: hdl/slsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/slsf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsf_dp
// Tap datapath: weight update, product register, accumulator and final sum.
// ----------------------------------------------------------------------------
module slsf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slsf_pkg::dp_ctrl_t            ctl,
  input  logic [slsf_pkg::DATA_W-1:0]   residual,
  input  logic [slsf_pkg::DATA_W-1:0]   w_rd,
  input  logic [slsf_pkg::DATA_W-1:0]   h_rd,
  output logic [slsf_pkg::DATA_W-1:0]   w_upd,
  output logic                          busy,
  output logic [slsf_pkg::DATA_W-1:0]   synth
);

  logic [slsf_pkg::DATA_W-1:0] w_eff;
  logic [slsf_pkg::DATA_W-1:0] h_eff;
  logic [slsf_pkg::DATA_W-1:0] prod_r;
  logic                        prod_vld_r;
  logic [slsf_pkg::DATA_W-1:0] acc_r;
  logic [slsf_pkg::DATA_W-1:0] res_r;
  logic [slsf_pkg::DATA_W-1:0] pred;

  // Unwritten entries read as zero
  assign w_eff = ctl.w_ok ? w_rd : '0;
  assign h_eff = ctl.h_ok ? h_rd : '0;

  // Step the weight towards the sign of the residual
  assign w_upd = ctl.neg ? (w_eff - h_eff) : (w_eff + h_eff);

  // Track product occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (ctl.start) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.s1_vld;
    end
  end

  // Multiply one tap, accumulate the previous product
  always_ff @(posedge clk) begin
    prod_r <= slsf_pkg::DATA_W'(w_eff * h_eff);
    if (ctl.start) begin
      acc_r <= slsf_pkg::ROUND_HALF;
      res_r <= residual;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign busy  = prod_vld_r;
  assign pred  = slsf_pkg::DATA_W'($signed(acc_r) >>> slsf_pkg::FRAC_BITS);
  assign synth = res_r + pred;

endmodule

// File: hdl/slsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsf_ctrl
// Sequencer: item intake, loads, tap walk over both stores, history push.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slsf_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input item
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [slsf_pkg::MODE_W-1:0]    in_mode,
  input  logic [slsf_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [slsf_pkg::DATA_W-1:0]    in_value,
  input  logic [slsf_pkg::SHIFT_W-1:0]   in_load_shift,
  // Tap count register
  input  logic                           cfg_wr_en,
  input  logic [slsf_pkg::CFG_W-1:0]     cfg_wr_data,
  // Store ports
  output slsf_pkg::ram_wr_t              w_wr,
  output slsf_pkg::ram_wr_t              h_wr,
  output logic [slsf_pkg::TAP_AW-1:0]    w_raddr,
  output logic [slsf_pkg::TAP_AW-1:0]    h_raddr,
  // Datapath
  output slsf_pkg::dp_ctrl_t             dp_ctl,
  input  logic [slsf_pkg::DATA_W-1:0]    w_upd,
  input  logic                           dp_busy,
  input  logic [slsf_pkg::DATA_W-1:0]    synth,
  // Result register handshake
  input  logic                           out_free,
  output logic                           push
);

  localparam logic [slsf_pkg::TAP_AW:0] RING_LEN = (slsf_pkg::TAP_AW + 1)'(slsf_pkg::MAX_TAPS);

  slsf_pkg::state_t state_r, state_nxt;

  logic [slsf_pkg::CFG_W-1:0]    taps_cfg_r;
  logic [slsf_pkg::CNT_W-1:0]    taps_lim;
  logic [slsf_pkg::CNT_W-1:0]    lim_r;
  logic [slsf_pkg::CNT_W-1:0]    cnt_r;
  logic [slsf_pkg::TAP_AW-1:0]   newest_r;
  logic [slsf_pkg::TAP_AW-1:0]   newest_dec;
  logic [slsf_pkg::MAX_TAPS-1:0] wt_ok_r;
  logic [slsf_pkg::MAX_TAPS-1:0] hist_ok_r;
  logic                          s1_vld_r;
  logic [slsf_pkg::TAP_AW-1:0]   s1_addr_r;
  logic                          s1_wok_r;
  logic                          s1_hok_r;
  logic                          neg_r;
  logic                          upd_r;

  logic                          accept;
  logic                          start;
  logic                          issue;
  logic                          idx_ok;
  logic [slsf_pkg::TAP_AW-1:0]   tap_addr;
  logic [slsf_pkg::TAP_AW-1:0]   load_addr;
  logic [slsf_pkg::TAP_AW:0]     run_sum;
  logic [slsf_pkg::TAP_AW:0]     load_sum;
  logic [slsf_pkg::TAP_AW-1:0]   run_slot;
  logic [slsf_pkg::TAP_AW-1:0]   load_slot;
  logic [slsf_pkg::DATA_W-1:0]   loaded;
  logic                          ld_w;
  logic                          ld_h;

  // Saturate the tap count to the built depth
  always_comb begin
    if (32'(taps_cfg_r) > slsf_pkg::MAX_TAPS) begin
      taps_lim = slsf_pkg::CNT_W'(slsf_pkg::MAX_TAPS);
    end else begin
      taps_lim = slsf_pkg::CNT_W'(taps_cfg_r);
    end
  end

  // Ring slot of history index k: (newest + k) wrapped once
  assign tap_addr  = cnt_r[slsf_pkg::TAP_AW-1:0];
  assign load_addr = slsf_pkg::TAP_AW'(in_entry_index);
  assign run_sum   = {1'b0, newest_r} + {1'b0, tap_addr};
  assign load_sum  = {1'b0, newest_r} + {1'b0, load_addr};
  assign run_slot  = (run_sum >= RING_LEN) ? slsf_pkg::TAP_AW'(run_sum - RING_LEN)
                                           : slsf_pkg::TAP_AW'(run_sum);
  assign load_slot = (load_sum >= RING_LEN) ? slsf_pkg::TAP_AW'(load_sum - RING_LEN)
                                            : slsf_pkg::TAP_AW'(load_sum);
  assign newest_dec = (newest_r == '0) ? slsf_pkg::TAP_AW'(slsf_pkg::MAX_TAPS - 1)
                                       : newest_r - slsf_pkg::TAP_AW'(1);

  assign accept = in_valid && !in_stall;
  assign idx_ok = 32'(in_entry_index) < slsf_pkg::MAX_TAPS;
  assign loaded = in_value << in_load_shift;
  assign start  = accept && (in_mode == slsf_pkg::MODE_RESIDUAL);
  assign ld_w   = accept && idx_ok && (in_mode == slsf_pkg::MODE_LOAD_WEIGHT);
  assign ld_h   = accept && idx_ok && (in_mode == slsf_pkg::MODE_LOAD_HIST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slsf_pkg::ST_IDLE:  if (start) state_nxt = slsf_pkg::ST_RUN;
      slsf_pkg::ST_RUN:   if (cnt_r >= lim_r) state_nxt = slsf_pkg::ST_DRAIN;
      slsf_pkg::ST_DRAIN: if (!s1_vld_r && !dp_busy) state_nxt = slsf_pkg::ST_PUSH;
      slsf_pkg::ST_PUSH:  if (out_free) state_nxt = slsf_pkg::ST_IDLE;
      default:            state_nxt = slsf_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    push     = 1'b0;
    case (state_r)
      slsf_pkg::ST_IDLE:  in_stall = 1'b0;
      slsf_pkg::ST_RUN:   issue = (cnt_r < lim_r);
      slsf_pkg::ST_DRAIN: issue = 1'b0;
      slsf_pkg::ST_PUSH:  push = out_free;
      default:            in_stall = 1'b1;
    endcase
  end

  // Store reads for the current tap
  assign w_raddr = tap_addr;
  assign h_raddr = run_slot;

  // Weight writes: a load while idle, otherwise the per-tap update
  always_comb begin
    if (ld_w) begin
      w_wr.we   = 1'b1;
      w_wr.addr = load_addr;
      w_wr.data = loaded;
    end else begin
      w_wr.we   = s1_vld_r && upd_r;
      w_wr.addr = s1_addr_r;
      w_wr.data = w_upd;
    end
  end

  // History writes: a load while idle, otherwise the new sample at push
  always_comb begin
    if (ld_h) begin
      h_wr.we   = 1'b1;
      h_wr.addr = load_slot;
      h_wr.data = loaded;
    end else begin
      h_wr.we   = push;
      h_wr.addr = newest_dec;
      h_wr.data = synth;
    end
  end

  assign dp_ctl.start  = start;
  assign dp_ctl.s1_vld = s1_vld_r;
  assign dp_ctl.w_ok   = s1_wok_r;
  assign dp_ctl.h_ok   = s1_hok_r;
  assign dp_ctl.neg    = neg_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= slsf_pkg::ST_IDLE;
      taps_cfg_r <= slsf_pkg::TAPS_RESET;
      newest_r   <= '0;
      wt_ok_r    <= '0;
      hist_ok_r  <= '0;
      s1_vld_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      if (cfg_wr_en) begin
        taps_cfg_r <= cfg_wr_data;
      end
      if (start) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + slsf_pkg::CNT_W'(1);
      end
      if (w_wr.we) begin
        wt_ok_r[w_wr.addr] <= 1'b1;
      end
      if (h_wr.we) begin
        hist_ok_r[h_wr.addr] <= 1'b1;
      end
      if (push) begin
        newest_r <= newest_dec;
      end
    end
  end

  // Per-item and per-tap payload
  always_ff @(posedge clk) begin
    if (start) begin
      lim_r <= taps_lim;
      neg_r <= in_value[slsf_pkg::DATA_W-1];
      upd_r <= (in_value != '0);
    end
    s1_addr_r <= tap_addr;
    s1_wok_r  <= wt_ok_r[tap_addr];
    s1_hok_r  <= hist_ok_r[run_slot];
  end

  // A tap update never lands while a load may be written
  `CHK_SAME(a_upd_not_idle, clk, rst_n, s1_vld_r && upd_r, state_r != slsf_pkg::ST_IDLE,
            "weight update while idle")
  // The tap walk never passes the captured tap count
  `CHK_SAME(a_cnt_bound, clk, rst_n, state_r == slsf_pkg::ST_RUN, cnt_r <= lim_r,
            "tap counter past limit")
  // A residual item starts the walk from tap zero
  `CHK_NEXT(a_start_walk, clk, rst_n, start,
            state_r == slsf_pkg::ST_RUN && cnt_r == '0, "walk did not start at tap zero")
  // The push only follows a drained pipeline
  `CHK_SAME(a_push_drained, clk, rst_n, push, !s1_vld_r && !dp_busy,
            "push with taps in flight")

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sign-LMS synthesis predictor core. A scoreboard
// predicts each reconstructed sample from its own copy of the weights, the
// history ring and the tap count. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [slsf_pkg::MODE_W-1:0] MODE_IGNORED = slsf_pkg::MODE_W'(3);
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_MAX   = 10;

  // Predicts reconstructed samples and checks them in order
  class sample_scoreboard;
    logic [slsf_pkg::DATA_W-1:0] weights [slsf_pkg::MAX_TAPS];
    logic [slsf_pkg::DATA_W-1:0] hist [slsf_pkg::MAX_TAPS];
    int                          newest;
    logic [slsf_pkg::CFG_W-1:0]  taps;
    logic [slsf_pkg::DATA_W-1:0] expected_samples [$];
    int                          n_errors;

    function new();
      foreach (weights[k]) begin
        weights[k] = '0;
        hist[k]    = '0;
      end
      newest   = 0;
      taps     = slsf_pkg::TAPS_RESET;
      n_errors = 0;
    endfunction

    function void set_taps(logic [slsf_pkg::CFG_W-1:0] value);
      taps = value;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // Apply one accepted item to the model state
    function void note_item(logic [slsf_pkg::MODE_W-1:0] mode,
                            logic [slsf_pkg::IDX_W-1:0] idx,
                            logic [slsf_pkg::DATA_W-1:0] value,
                            logic [slsf_pkg::SHIFT_W-1:0] shift);
      logic [slsf_pkg::DATA_W-1:0] loaded;
      logic [slsf_pkg::DATA_W-1:0] acc;
      logic [slsf_pkg::DATA_W-1:0] synth;
      logic [slsf_pkg::DATA_W-1:0] h;
      int                          n;
      loaded = value << shift;
      case (mode)
        slsf_pkg::MODE_LOAD_WEIGHT: begin
          if (idx < slsf_pkg::MAX_TAPS) weights[idx] = loaded;
        end
        slsf_pkg::MODE_LOAD_HIST: begin
          if (idx < slsf_pkg::MAX_TAPS)
            hist[(newest + idx) % slsf_pkg::MAX_TAPS] = loaded;
        end
        slsf_pkg::MODE_RESIDUAL: begin
          n = (taps > slsf_pkg::MAX_TAPS) ? slsf_pkg::MAX_TAPS : int'(taps);
          // Rounded dot product, arithmetic shift down
          acc = slsf_pkg::ROUND_HALF;
          for (int k = 0; k < n; k++)
            acc += weights[k] * hist[(newest + k) % slsf_pkg::MAX_TAPS];
          acc   = $signed(acc) >>> slsf_pkg::FRAC_BITS;
          synth = value + acc;
          // Sign-LMS weight update, skipped for a zero residual
          if (value != '0) begin
            for (int k = 0; k < n; k++) begin
              h = hist[(newest + k) % slsf_pkg::MAX_TAPS];
              if (value[slsf_pkg::DATA_W-1]) weights[k] -= h;
              else weights[k] += h;
            end
          end
          // Push the new sample as most recent
          newest       = (newest + slsf_pkg::MAX_TAPS - 1) % slsf_pkg::MAX_TAPS;
          hist[newest] = synth;
          expected_samples.push_back(synth);
        end
        default: ;
      endcase
    endfunction

    function void check_sample(logic [slsf_pkg::DATA_W-1:0] got);
      logic [slsf_pkg::DATA_W-1:0] want;
      if (expected_samples.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("unexpected sample %0d", $signed(got));
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("sample mismatch: expected %0d (%h) got %0d (%h)",
                   $signed(want), want, $signed(got), got);
      end
    endfunction

    function void count_leftovers();
      if (expected_samples.size() != 0) begin
        n_errors += expected_samples.size();
        $display("%0d samples never arrived", expected_samples.size());
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_wr_en;
  logic [slsf_pkg::CFG_W-1:0]          cfg_wr_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [slsf_pkg::MODE_W-1:0]         in_mode;
  logic [slsf_pkg::IDX_W-1:0]          in_entry_index;
  logic signed [slsf_pkg::DATA_W-1:0]  in_value;
  logic [slsf_pkg::SHIFT_W-1:0]        in_load_shift;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [slsf_pkg::DATA_W-1:0]  out_sample_out;

  int               send_idle_pct;
  int               recv_idle_pct;
  logic             hold_rx;
  int               cycle_count;
  sample_scoreboard sb;

  sign_lms_synthesis_filter_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .in_load_shift  (in_load_shift),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check each accepted sample, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_sample(out_sample_out);
    out_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
  end

  // Abort a run that hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offer one item, idling first at random; return at the accepting edge
  task automatic send_item(input logic [slsf_pkg::MODE_W-1:0] mode,
                           input logic [slsf_pkg::IDX_W-1:0] idx,
                           input logic [slsf_pkg::DATA_W-1:0] value,
                           input logic [slsf_pkg::SHIFT_W-1:0] shift);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= idx;
    in_value       <= value;
    in_load_shift  <= shift;
    do @(posedge clk); while (in_stall);
    sb.note_item(mode, idx, value, shift);
  endtask

  // Drop valid and wait until every sample is back and the core is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(input logic [slsf_pkg::CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_taps(value);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly audio-like magnitudes, some full-range and corner values
  function automatic logic [slsf_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom();
      1: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      2, 3: return slsf_pkg::DATA_W'($urandom_range(1 << 20)) - slsf_pkg::DATA_W'(1 << 19);
      default: return slsf_pkg::DATA_W'($urandom_range(600)) - slsf_pkg::DATA_W'(300);
    endcase
  endfunction

  function automatic logic [slsf_pkg::SHIFT_W-1:0] pick_shift(input int lo, input int hi);
    if ($urandom_range(3) == 0) return slsf_pkg::SHIFT_W'($urandom_range(31));
    return slsf_pkg::SHIFT_W'($urandom_range(hi, lo));
  endfunction

  // Weights in fixed point, history as plain samples, residuals in between
  task automatic send_random_item(output bit counted);
    int unsigned r;
    r       = $urandom_range(99);
    counted = 1'b1;
    if (r < 10)
      send_item(slsf_pkg::MODE_LOAD_WEIGHT, slsf_pkg::IDX_W'($urandom_range(31)),
                pick_value(), pick_shift(10, slsf_pkg::FRAC_BITS));
    else if (r < 18)
      send_item(slsf_pkg::MODE_LOAD_HIST, slsf_pkg::IDX_W'($urandom_range(31)),
                pick_value(), pick_shift(0, 4));
    else if (r < 21) begin
      send_item(MODE_IGNORED, slsf_pkg::IDX_W'($urandom_range(31)), $urandom(),
                slsf_pkg::SHIFT_W'($urandom_range(31)));
      counted = 1'b0;
    end else
      send_item(slsf_pkg::MODE_RESIDUAL, slsf_pkg::IDX_W'($urandom_range(31)),
                pick_value(), slsf_pkg::SHIFT_W'($urandom_range(31)));
  endtask

  task automatic run_phase(input logic [slsf_pkg::CFG_W-1:0] taps, input int sidle,
                           input int ridle, input int n_items, input bit with_hold);
    int sent;
    bit counted;
    sent = 0;
    settle();
    send_idle_pct <= sidle;
    recv_idle_pct <= ridle;
    write_taps(taps);
    // Hold the receiver off while items keep coming
    if (with_hold) begin
      fork
        begin
          hold_rx <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_rx <= 1'b0;
        end
      join_none
    end
    while (sent < n_items) begin
      send_random_item(counted);
      if (counted) sent++;
    end
  endtask

  // Corner items at the reset tap count, then no taps and an oversized count
  task automatic run_directed();
    send_item(slsf_pkg::MODE_LOAD_WEIGHT, 5'd0, 32'd1, 5'd14);
    send_item(slsf_pkg::MODE_LOAD_WEIGHT, 5'd31, 32'h7FFF_FFFF, 5'd0);
    send_item(slsf_pkg::MODE_LOAD_WEIGHT, 5'd1, 32'hFFFF_FFFF, 5'd31);
    send_item(slsf_pkg::MODE_LOAD_WEIGHT, 5'd2, -32'sd3, 5'd13);
    send_item(slsf_pkg::MODE_LOAD_HIST, 5'd0, 32'h8000_0000, 5'd0);
    send_item(slsf_pkg::MODE_LOAD_HIST, 5'd31, 32'd123, 5'd5);
    send_item(slsf_pkg::MODE_LOAD_HIST, 5'd10, -32'sd5, 5'd3);
    send_item(MODE_IGNORED, 5'd31, 32'hFFFF_FFFF, 5'd31);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'd0, 5'd0);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd31, 32'h7FFF_FFFF, 5'd31);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'h8000_0000, 5'd0);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'd1, 5'd0);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'hFFFF_FFFF, 5'd0);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'd100, 5'd0);
    send_item(slsf_pkg::MODE_LOAD_WEIGHT, 5'd9, 32'd5, 5'd14);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, -32'sd250, 5'd0);
    settle();
    write_taps(slsf_pkg::CFG_W'(0));
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'd1000, 5'd0);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, -32'sd1000, 5'd0);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'd0, 5'd0);
    settle();
    write_taps(slsf_pkg::CFG_W'(63));
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'd12345, 5'd0);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, -32'sd7, 5'd0);
    send_item(slsf_pkg::MODE_LOAD_HIST, 5'd20, 32'h5555_5555, 5'd1);
    send_item(slsf_pkg::MODE_RESIDUAL, 5'd0, 32'h4000_0000, 5'd0);
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_mode        = slsf_pkg::MODE_RESIDUAL;
    in_entry_index = '0;
    in_value       = '0;
    in_load_shift  = '0;
    out_stall      = 1'b0;
    hold_rx        = 1'b0;
    send_idle_pct  = 24;
    recv_idle_pct  = 76;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_phase(slsf_pkg::CFG_W'(32), 24, 76, 200, 1'b0);
    run_phase(slsf_pkg::CFG_W'(0), 24, 76, 40, 1'b0);
    run_phase(slsf_pkg::CFG_W'(1), 76, 24, 120, 1'b0);
    run_phase(slsf_pkg::CFG_W'($urandom_range(31, 2)), 76, 24, 120, 1'b0);
    run_phase(slsf_pkg::CFG_W'(63), 0, 0, 160, 1'b1);
    run_phase(slsf_pkg::CFG_W'(17), 0, 0, 60, 1'b0);
    settle();

    sb.count_leftovers();
    if (sb.n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: sign_lms_synthesis_filter_core.f
+incdir+hdl
hdl/slsf_pkg.sv
hdl/slsf_ram.sv
hdl/slsf_dp.sv
hdl/slsf_ctrl.sv
hdl/sign_lms_synthesis_filter_core.sv
bench/tb.sv
